@@ rtl/core/ate_pkg.sv @@
package ate_pkg;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC = 16;
  localparam int GUARD_BITS = 8;
  localparam int TABLE_LEN = 24;
  localparam int REG_ADC_OFFSET = 0;
  localparam int REG_DEAD_BAND = 1;
  localparam logic [9:0] ADC_OFFSET_RST = 10'd385;
  localparam logic [11:0] DEAD_BAND_RST = 12'd640;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0: v = 22'd2949120;  5'd1: v = 22'd1740967; 5'd2: v = 22'd919879;
      5'd3: v = 22'd466945;   5'd4: v = 22'd234379;  5'd5: v = 22'd117305;
      5'd6: v = 22'd58665;    5'd7: v = 22'd29335;   5'd8: v = 22'd14668;
      5'd9: v = 22'd7334;     5'd10: v = 22'd3667;   5'd11: v = 22'd1833;
      5'd12: v = 22'd917;     5'd13: v = 22'd458;    5'd14: v = 22'd229;
      5'd15: v = 22'd115;     5'd16: v = 22'd57;     5'd17: v = 22'd29;
      5'd18: v = 22'd14;      5'd19: v = 22'd7;      5'd20: v = 22'd4;
      5'd21: v = 22'd2;       5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction
endpackage

@@ rtl/core/accel_tilt_estimator_top.sv @@
// Tilt estimator: one item of three raw axis samples gives one pitch/roll
// pair in signed Q7.8 degrees. Items are processed one at a time: an item
// passes through the bit-serial divide by ten in the filter, the bit-serial
// squaring, the two-bit-per-cycle root and the CORDIC loop, and no new input
// is taken while the result waits for m_tready. Pitch and roll run on two
// copies of the angle unit in parallel.
module accel_tilt_estimator_top import ate_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // accel_x, accel_y, accel_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata                          // pitch_angle, roll_angle
);
  localparam int SB = SAMPLE_BITS + FRACTION_BITS + 2;
  localparam int PW = SB + 5;
  localparam logic [PW-1:0] QPOS = PW'((64'd1 << (SB-1)) - 64'd1);
  localparam logic [PW-1:0] QNEG = PW'(64'd1 << (SB-1));

  logic [9:0] adc_offset;
  logic [11:0] dead_band;
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_offset <= ADC_OFFSET_RST; dead_band <= DEAD_BAND_RST;
    end else if (cfg_we) begin
      if (cfg_index == 1'(REG_ADC_OFFSET)) adc_offset <= cfg_data[9:0];
      else dead_band <= cfg_data[11:0];
    end
  end

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_LOAD, S_ANGLE, S_HOLD} st_t;
  st_t st;

  logic signed [SB-1:0] recent [3];
  logic signed [SB-1:0] older [3];
  logic [PW-1:0] dvd [3];           // dividend in, quotient out
  logic [3:0] rmd [3];              // partial remainder
  logic [2:0] neg;
  logic [5:0] dcnt;
  logic start, dp, dr;
  logic [15:0] pa, ra;
  logic signed [PW-1:0] fsum [3];
  logic [4:0] rsh [3];

  // filter sum: (s - off) << F + 6r + 3o
  function automatic logic signed [PW-1:0] filt_sum(input logic [SAMPLE_BITS-1:0] s,
      input logic [9:0] off, input logic signed [SB-1:0] r,
      input logic signed [SB-1:0] o);
    logic signed [PW-1:0] d;
    d = PW'($signed({1'b0, s})) - PW'($signed({1'b0, SAMPLE_BITS'(off)}));
    return (d <<< FRACTION_BITS) + (PW'(r) <<< 2) + (PW'(r) <<< 1)
           + (PW'(o) <<< 1) + PW'(o);
  endfunction

  // magnitude plus half the divisor, for rounding ties away from zero
  function automatic logic [PW-1:0] round_mag(input logic signed [PW-1:0] v);
    logic [PW-1:0] m;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    return m + PW'(5);
  endfunction

  // restore sign and saturate to the state width
  function automatic logic [SB-1:0] sat_q(input logic [PW-1:0] q, input logic ng);
    logic [PW-1:0] m;
    if (ng) m = (q > QNEG) ? QNEG : q;
    else m = (q > QPOS) ? QPOS : q;
    m = ng ? -m : m;
    return m[SB-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fsum[i] = filt_sum(s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS], adc_offset,
                         recent[i], older[i]);
      rsh[i] = {rmd[i], dvd[i][PW-1]};
    end
  end

  assign s_tready = (st == S_IDLE);

  // item sequencing: filter divide, history update, angles, result hold
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; start <= 1'b0; m_tvalid <= 1'b0;
      for (int i = 0; i < 3; i++) begin recent[i] <= '0; older[i] <= '0; end
    end else begin
      start <= (st == S_LOAD);
      unique case (st)
        S_IDLE: if (s_tvalid) begin
          for (int i = 0; i < 3; i++) begin
            dvd[i] <= round_mag(fsum[i]); rmd[i] <= '0; neg[i] <= fsum[i][PW-1];
          end
          dcnt <= '0; st <= S_DIV;
        end
        // restoring divide by ten, one quotient bit per cycle
        S_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (rsh[i] >= 5'd10) begin
              rmd[i] <= 4'(rsh[i] - 5'd10); dvd[i] <= {dvd[i][PW-2:0], 1'b1};
            end else begin
              rmd[i] <= rsh[i][3:0]; dvd[i] <= {dvd[i][PW-2:0], 1'b0};
            end
          end
          if (dcnt == 6'(PW-1)) st <= S_LOAD;
          else dcnt <= dcnt + 6'd1;
        end
        S_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            older[i] <= recent[i];
            recent[i] <= sat_q(dvd[i], neg[i]);
          end
          st <= S_ANGLE;
        end
        S_ANGLE: if (dp && dr) begin
          m_tdata <= {ra, pa}; m_tvalid <= 1'b1; st <= S_HOLD;
        end
        S_HOLD: if (m_tready) begin
          m_tvalid <= 1'b0; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  ate_angle #(.SB(SB), .FRACTION_BITS(FRACTION_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk, .rst, .start, .num(recent[0]), .a(recent[1]), .b(recent[2]),
    .dead_band, .done(dp), .angle(pa));
  ate_angle #(.SB(SB), .FRACTION_BITS(FRACTION_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk, .rst, .start, .num(recent[1]), .a(recent[0]), .b(recent[2]),
    .dead_band, .done(dr), .angle(ra));
endmodule

@@ rtl/core/ate_angle.sv @@
// One tilt angle: bit-serial root of a^2+b^2, then CORDIC vectoring of
// (root, num), then rounding, saturation and dead band.
module ate_angle import ate_pkg::*; #(
  parameter int SB = 20,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [SB-1:0] num,
  input  logic signed [SB-1:0] a,
  input  logic signed [SB-1:0] b,
  input  logic [11:0]          dead_band,
  output logic                 done,
  output logic [15:0]          angle
);
  localparam int SQW = 2*SB;        // sum of squares width
  localparam int RW = SB;           // root width
  localparam int CW = SB + GUARD_BITS + 3;
  localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int SH = ANGLE_FRAC - FRACTION_BITS;
  localparam int IW = $clog2(SB);   // bit index into a magnitude

  typedef enum logic [2:0] {IDLE, MUL, ROOT, CORD, FIN} st_t;
  st_t st;

  logic [SB-1:0] ma, mb;            // magnitudes
  logic [SQW:0] acc;                // sum of squares
  logic [SQW+1:0] rem;
  logic [RW:0] root;
  logic [5:0] cnt;
  logic signed [CW-1:0] cx, cy;
  logic signed [23:0] z;
  logic signed [SB-1:0] nreg;

  logic [SB-1:0] amag, bmag;
  assign amag = a[SB-1] ? SB'(-a) : SB'(a);
  assign bmag = b[SB-1] ? SB'(-b) : SB'(b);

  // root step: two bits of sum enter per cycle
  logic [SQW+1:0] trial, rem_sh;
  assign rem_sh = {rem[SQW-1:0], acc[SQW-1 -: 2]};
  assign trial = rem_sh - {{(SQW+1-RW-2){1'b0}}, root, 2'b01};

  // CORDIC step with floor shifts; iteration cnt uses table entry cnt-1
  logic [4:0] k;
  assign k = 5'(cnt - 6'd1);
  logic signed [CW-1:0] dx, dy;
  assign dx = cy >>> k;
  assign dy = cx >>> k;
  logic [21:0] at;
  assign at = atan_entry(k);

  // output rounding
  logic [23:0] zmag, rmag;
  logic [15:0] omag;
  assign zmag = z[23] ? 24'(-z) : 24'(z);
  always_comb begin
    rmag = (SH > 0) ? 24'((zmag + (24'd1 << (SH-1))) >> SH) : zmag;
    if (z[23]) omag = (rmag > 24'd32768) ? 16'h8000 : rmag[15:0];
    else omag = (rmag > 24'd32767) ? 16'h7fff : rmag[15:0];
    if ({4'd0, omag} < {8'd0, dead_band}) omag = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= IDLE;
      done <= 1'b0;
    end else begin
      done <= (st == FIN);
      unique case (st)
        IDLE: if (start) begin
          ma <= amag; mb <= bmag; nreg <= num; acc <= '0; cnt <= '0;
          st <= MUL;
        end
        // shift-add squares, one multiplier bit per cycle
        MUL: begin
          acc <= acc + (ma[cnt[IW-1:0]] ? ((SQW+1)'(ma) << cnt) : '0)
                     + (mb[cnt[IW-1:0]] ? ((SQW+1)'(mb) << cnt) : '0);
          if (cnt == 6'(SB-1)) begin
            cnt <= '0; rem <= '0; root <= '0; st <= ROOT;
          end else cnt <= cnt + 6'd1;
        end
        ROOT: begin
          if (!trial[SQW+1]) begin
            rem <= trial; root <= {root[RW-1:0], 1'b1};
          end else begin
            rem <= rem_sh; root <= {root[RW-1:0], 1'b0};
          end
          acc <= acc << 2;
          if (cnt == 6'(SB-1)) begin
            cnt <= '0; st <= CORD;
          end else cnt <= cnt + 6'd1;
        end
        CORD: begin
          if (cnt == 6'd0) begin
            cx <= CW'({1'b0, root[RW-1:0]}) <<< GUARD_BITS;
            cy <= CW'(nreg) <<< GUARD_BITS;
            z <= '0;
            cnt <= 6'd1;
          end else begin
            if (cy > 0) begin
              cx <= cx + dx; cy <= cy - dy;
              z <= z + 24'(at);
            end else begin
              cx <= cx - dx; cy <= cy + dy;
              z <= z - 24'(at);
            end
            if (cnt == 6'(STEPS)) st <= FIN;
            else cnt <= cnt + 6'd1;
          end
        end
        FIN: begin
          if (nreg == '0) z <= '0;
          else if (root[RW-1:0] == '0) z <= nreg[SB-1] ? -24'sd5898240 : 24'sd5898240;
          st <= IDLE;
        end
        default: st <= IDLE;
      endcase
    end
  end

  assign angle = z[23] ? 16'(-omag) : omag;
endmodule

@@ sim/tb_accel_tilt_estimator_top.sv @@
`timescale 1ns / 1ps

module tb_accel_tilt_estimator_top;
  import ate_pkg::*;

  localparam int ITEM_CYCLES = 3 * (SAMPLE_BITS_DEF + FRACTION_BITS_DEF + 2)
                               + CORDIC_STEPS_DEF + 12;
  localparam int IDLE_LIMIT  = 20 * ITEM_CYCLES;

  // Tilt predictor: filter history, register copies and the pending angle pairs
  class tilt_scoreboard;
    longint      recent_f[3];
    longint      older_f[3];
    logic [9:0]  offset_reg;
    logic [11:0] band_reg;
    logic [31:0] angle_q[$];
    int          mismatches;
    int          checked;

    // atan(2^-i) in degrees, 16 fraction bits
    longint atan_deg[16] = '{2949120, 1740967, 919879, 466945, 234379, 117305,
                             58665, 29335, 14668, 7334, 3667, 1833, 917, 458,
                             229, 115};

    function void reset_state();
      for (int a = 0; a < 3; a++) begin
        recent_f[a] = 0;
        older_f[a] = 0;
      end
      offset_reg = ADC_OFFSET_RST;
      band_reg = DEAD_BAND_RST;
      angle_q.delete();
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(int idx, logic [11:0] val);
      if (idx == REG_ADC_OFFSET) offset_reg = val[9:0];
      else band_reg = val;
    endfunction

    function longint unsigned int_root(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // degrees * 2^16 of atan2(num, sqrt(a^2 + b^2))
    function longint tilt(longint num, longint a, longint b);
      longint unsigned r;
      longint cx, cy, dx, dy, z;
      r = int_root(a * a + b * b);
      z = 0;
      if (num == 0) return 0;
      if (r == 0) return (num > 0) ? 90 * 65536 : -90 * 65536;
      cx = longint'(r) * 256;
      cy = num * 256;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx += dx; cy -= dy; z += atan_deg[i];
        end else begin
          cx -= dx; cy += dy; z -= atan_deg[i];
        end
      end
      return z;
    endfunction

    // round to Q7.8, saturate, apply dead band
    function logic [15:0] to_q78(longint z);
      longint m;
      bit neg;
      neg = z < 0;
      m = neg ? -z : z;
      m = (m + 128) >> 8;
      if (neg && m > 32768) m = 32768;
      if (!neg && m > 32767) m = 32767;
      if (m < band_reg) m = 0;
      return neg ? 16'(-m) : 16'(m);
    endfunction

    function void note_input(logic [9:0] ax, logic [9:0] ay, logic [9:0] az);
      longint smp[3];
      longint sum, q;
      smp[0] = ax; smp[1] = ay; smp[2] = az;
      for (int a = 0; a < 3; a++) begin
        sum = (smp[a] - offset_reg) * 256 + 6 * recent_f[a] + 3 * older_f[a];
        q = ((sum < 0 ? -sum : sum) + 5) / 10;
        if (sum < 0) q = -q;
        if (q > 524287) q = 524287;
        if (q < -524288) q = -524288;
        older_f[a] = recent_f[a];
        recent_f[a] = q;
      end
      angle_q.push_back({to_q78(tilt(recent_f[1], recent_f[0], recent_f[2])),
                         to_q78(tilt(recent_f[0], recent_f[1], recent_f[2]))});
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] exp_v;
      checked++;
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_v = angle_q.pop_front();
      if (got[15:0] !== exp_v[15:0] || got[31:16] !== exp_v[31:16]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: pitch exp %0d got %0d, roll exp %0d got %0d", checked,
                   $signed(exp_v[15:0]), $signed(got[15:0]),
                   $signed(exp_v[31:16]), $signed(got[31:16]));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [11:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // accel_x, accel_y, accel_z
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // pitch_angle, roll_angle

  tilt_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int cyc = 0;

  accel_tilt_estimator_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each transfer, stall on a shifting pattern
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    case (cyc[10:9])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= cyc[4];
    endcase
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("accel_tilt_estimator_top test failed");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [11:0] val);
    cfg_we <= 1'b1;
    cfg_index <= 1'(idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Wait until every expected angle pair is back, then let the core settle
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.angle_q.size() != 0) @(posedge clk);
    repeat (2 * ITEM_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(logic [9:0] ax, logic [9:0] ay, logic [9:0] az);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, az, ay, ax};
    do @(posedge clk); while (!s_tready);
    sb.note_input(ax, ay, az);
    burst_left--;
  endtask

  function automatic logic [9:0] near_offset();
    int v;
    v = int'(sb.offset_reg) + $urandom_range(0, 64) - 32;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  task automatic random_items(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 7)
        send_item(10'($urandom), 10'($urandom), 10'($urandom));
      else
        send_item(near_offset(), near_offset(), near_offset());
    end
  endtask

  initial begin
    logic [9:0] off;
    sb.reset_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset registers, zero-root and zero-numerator cases, extremes
    off = ADC_OFFSET_RST;
    for (int k = 0; k < 4; k++) send_item(10'd1023, off, off);  // pitch +90, roll 0
    for (int k = 0; k < 4; k++) send_item(10'd0, off, off);     // pitch toward -90
    for (int k = 0; k < 3; k++) send_item(off, off, off);       // all decaying
    send_item(10'd0, 10'd0, 10'd0);
    send_item(10'd1023, 10'd1023, 10'd1023);
    send_item(10'd1023, 10'd0, 10'd1023);
    send_item(off, 10'd1023, 10'd0);
    send_item(10'd386, 10'd385, 10'd900);                        // near the dead band
    drain();

    // Offset zero, no dead band
    write_reg(REG_ADC_OFFSET, 12'd0);
    write_reg(REG_DEAD_BAND, 12'd0);
    for (int k = 0; k < 3; k++) send_item(10'd0, 10'd0, 10'd0);
    send_item(10'd1023, 10'd0, 10'd0);
    send_item(10'd1, 10'd1, 10'd1);
    random_items(120);
    drain();

    // Offset at top, dead band of 2560 (10 degrees)
    write_reg(REG_ADC_OFFSET, 12'd1023);
    write_reg(REG_DEAD_BAND, 12'd2560);
    send_item(10'd0, 10'd1023, 10'd1023);
    random_items(120);
    drain();

    // Mid offset, dead band at field maximum; then a small band and random offset; then reset values
    write_reg(REG_ADC_OFFSET, 12'd512);
    write_reg(REG_DEAD_BAND, 12'd4095);
    random_items(60);
    drain();
    write_reg(REG_DEAD_BAND, 12'd100);
    write_reg(REG_ADC_OFFSET, 12'($urandom_range(0, 1023)));
    random_items(100);
    drain();
    write_reg(REG_ADC_OFFSET, 12'd385);
    write_reg(REG_DEAD_BAND, 12'd640);
    random_items(100);

    // Final drain and settle
    s_tvalid <= 1'b0;
    while (sb.angle_q.size() != 0) @(posedge clk);
    repeat (2 * ITEM_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.angle_q.size() == 0)
      $display("accel_tilt_estimator_top test passed");
    else
      $display("accel_tilt_estimator_top test failed");
    $finish;
  end

endmodule
